@@ hw/rtl/pcm_channel_downmix_macros.svh @@
// ----------------------------------------------------------------------------
// pcm_channel_downmix_macros
// assertion macros used by the downmix rtl
// ----------------------------------------------------------------------------
`ifndef PCM_CHANNEL_DOWNMIX_MACROS_SVH
`define PCM_CHANNEL_DOWNMIX_MACROS_SVH

// same-cycle implication under synchronous reset
`define PDM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("downmix assertion failed");

// next-cycle implication under synchronous reset
`define PDM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("downmix assertion failed");

`endif

@@ hw/rtl/pdm_pkg.sv @@
// ----------------------------------------------------------------------------
// pdm_pkg
// widths, format codes and register indexes of the pcm downmix
// ----------------------------------------------------------------------------
package pdm_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int MIX_W      = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam int CHAN_W     = 8;
    localparam int FMT_W      = 2;

    typedef logic [SAMPLE_W-1:0]   t_sample;
    typedef logic signed [MIX_W-1:0] t_mix;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;
    typedef logic [CHAN_W-1:0]     t_chan;
    typedef logic [FMT_W-1:0]      t_fmt;

    // register indexes
    localparam t_cfg_idx REG_NUM_CHANNELS  = 8'd0;
    localparam t_cfg_idx REG_INPUT_FORMAT  = 8'd1;
    localparam t_cfg_idx REG_OUTPUT_FORMAT = 8'd2;

    // input formats
    localparam t_fmt IFMT_U8  = 2'd0;
    localparam t_fmt IFMT_S16 = 2'd1;
    localparam t_fmt IFMT_S32 = 2'd2;

    // output formats
    localparam t_fmt OFMT_S8  = 2'd0;
    localparam t_fmt OFMT_S16 = 2'd1;
    localparam t_fmt OFMT_S32 = 2'd2;

endpackage

@@ hw/rtl/pdm_if.sv @@
// ----------------------------------------------------------------------------
// pdm_if
// valid/ready channels of the pcm downmix: samples, results, register writes
// ----------------------------------------------------------------------------
interface pdm_sample_if import pdm_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample_word;

    modport source (output valid, output sample_word, input ready);
    modport sink   (input valid, input sample_word, output ready);
endinterface

interface pdm_mix_if import pdm_pkg::*; ();
    logic valid;
    logic ready;
    t_mix mixed_sample;

    modport source (output valid, output mixed_sample, input ready);
    modport sink   (input valid, input mixed_sample, output ready);
endinterface

interface pdm_cfg_if import pdm_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/pcm_channel_downmix.sv @@
// ----------------------------------------------------------------------------
// pcm_channel_downmix
// bit-serial mixer of interleaved pcm channel samples down to one mono sample
// ----------------------------------------------------------------------------
// i_sample takes one channel sample per transfer; o_mix gives one sample per
// frame; i_cfg writes num_channels, input_format and output_format, is always
// ready; writes must go in while the block is idle, the block does not check.
// a sample is normalized and added to the frame sum one bit per cycle, so a
// sample that does not end a frame keeps ready low until its serial add is
// done, and no new sample is taken while one is being added.
// the last sample of a frame adds three more serial passes: sign magnitude,
// restoring division by the channel count one quotient bit per cycle, and
// the sign back. the result is then registered into o_mix from S_OUT, and
// the next sample can transfer once the block is back in idle.
// o_mix is a register: the next sample is taken while a result waits, and
// only the following frame end waits for the receiver to take it.
// reset clears the frame, drops any pending result and loads the register
// defaults: one channel, 16-bit input, 16-bit output.
// ----------------------------------------------------------------------------
module pcm_channel_downmix import pdm_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pdm_sample_if.sink   i_sample,
    pdm_mix_if.source    o_mix,
    pdm_cfg_if.sink      i_cfg
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADD  = 3'd1;
    localparam logic [2:0] S_NEG1 = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_NEG2 = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam logic [4:0] CNT_LAST = 5'd31;

    logic [2:0]  r_state, n_state;
    logic [4:0]  r_cnt, n_cnt;
    t_chan       r_num_ch, n_num_ch;
    t_fmt        r_in_fmt, n_in_fmt;
    t_fmt        r_out_fmt, n_out_fmt;
    logic [31:0] r_sum, n_sum;
    t_chan       r_idx, n_idx;
    logic        r_last, n_last;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_opnd, n_opnd;
    logic        r_carry, n_carry;
    logic [31:0] r_acc, n_acc;
    logic        r_neg, n_neg;
    t_chan       r_rem, n_rem;
    t_mix        r_out, n_out;

    t_chan       w_count;
    logic [31:0] w_norm;
    logic        w_cin;
    logic        w_add_bit, w_add_cy;
    logic        w_neg_bit, w_neg_cy;
    logic [8:0]  w_trial, w_diff;
    logic        w_ge;
    t_sample     w_word;
    logic        w_add_done;
    logic        w_frame_clear;

    assign w_word  = i_sample.sample_word;
    assign w_count = (r_num_ch == '0) ? t_chan'(1) : r_num_ch;

    assign i_sample.ready     = (r_state == S_IDLE);
    assign i_cfg.ready        = 1'b1;
    assign o_mix.valid        = r_out_valid;
    assign o_mix.mixed_sample = r_out;

    // normalize to 16-bit scale, the 32-bit rounding fix goes in as carry
    always_comb begin
        w_norm = '0;
        w_cin  = 1'b0;
        case (r_in_fmt)
            IFMT_U8: begin
                w_norm = {{16{~w_word[7]}}, ~w_word[7], w_word[6:0], 8'h00};
            end
            IFMT_S16: begin
                w_norm = {{16{w_word[15]}}, w_word[15:0]};
            end
            IFMT_S32: begin
                w_norm = {{16{w_word[31]}}, w_word[31:16]};
                w_cin  = w_word[31] & (|w_word[15:0]);
            end
            default: begin
                w_norm = '0;
            end
        endcase
    end

    // serial datapath bits
    assign w_add_bit = r_sum[0] ^ r_opnd[0] ^ r_carry;
    assign w_add_cy  = (r_sum[0] & r_opnd[0]) | (r_carry & (r_sum[0] ^ r_opnd[0]));
    assign w_neg_bit = r_neg ? (~r_acc[0] ^ r_carry) : r_acc[0];
    assign w_neg_cy  = r_carry & ~r_acc[0];
    assign w_trial   = {r_rem, r_acc[31]};
    assign w_ge      = (w_trial >= {1'b0, w_count});
    assign w_diff    = w_trial - {1'b0, w_count};

    assign w_add_done    = (r_state == S_ADD) && (r_cnt == CNT_LAST);
    assign w_frame_clear = (r_sum == '0) && (r_idx == '0);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_num_ch    = r_num_ch;
        n_in_fmt    = r_in_fmt;
        n_out_fmt   = r_out_fmt;
        n_sum       = r_sum;
        n_idx       = r_idx;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_opnd      = r_opnd;
        n_carry     = r_carry;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_rem       = r_rem;
        n_out       = r_out;

        if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_NUM_CHANNELS:  n_num_ch  = i_cfg.data[CHAN_W-1:0];
                REG_INPUT_FORMAT:  n_in_fmt  = i_cfg.data[FMT_W-1:0];
                REG_OUTPUT_FORMAT: n_out_fmt = i_cfg.data[FMT_W-1:0];
                default: begin
                end
            endcase
        end

        if (o_mix.valid && o_mix.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_sample.valid) begin
                    n_opnd  = w_norm;
                    n_carry = w_cin;
                    n_last  = (({1'b0, r_idx} + 9'd1) >= {1'b0, w_count});
                    n_cnt   = '0;
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_sum   = {w_add_bit, r_sum[31:1]};
                n_opnd  = {1'b0, r_opnd[31:1]};
                n_carry = w_add_cy;
                n_cnt   = r_cnt + 5'd1;
                if (r_cnt == CNT_LAST) begin
                    if (r_last) begin
                        n_acc   = {w_add_bit, r_sum[31:1]};
                        n_neg   = w_add_bit;
                        n_sum   = '0;
                        n_idx   = '0;
                        n_carry = 1'b1;
                        n_state = S_NEG1;
                    end else begin
                        n_idx   = r_idx + t_chan'(1);
                        n_state = S_IDLE;
                    end
                end
            end
            S_NEG1: begin
                n_acc   = {w_neg_bit, r_acc[31:1]};
                n_carry = w_neg_cy;
                n_cnt   = r_cnt + 5'd1;
                if (r_cnt == CNT_LAST) begin
                    n_rem   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = w_ge ? w_diff[7:0] : w_trial[7:0];
                n_acc = {r_acc[30:0], w_ge};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == CNT_LAST) begin
                    n_carry = 1'b1;
                    n_state = S_NEG2;
                end
            end
            S_NEG2: begin
                n_acc   = {w_neg_bit, r_acc[31:1]};
                n_carry = w_neg_cy;
                n_cnt   = r_cnt + 5'd1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid) begin
                    case (r_out_fmt)
                        OFMT_S8:  n_out = {{24{r_acc[7]}}, r_acc[7:0]};
                        OFMT_S16: n_out = {{16{r_acc[15]}}, r_acc[15:0]};
                        OFMT_S32: n_out = r_acc;
                        default:  n_out = '0;
                    endcase
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_num_ch    <= t_chan'(1);
            r_in_fmt    <= IFMT_S16;
            r_out_fmt   <= OFMT_S16;
            r_sum       <= '0;
            r_idx       <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_num_ch    <= n_num_ch;
            r_in_fmt    <= n_in_fmt;
            r_out_fmt   <= n_out_fmt;
            r_sum       <= n_sum;
            r_idx       <= n_idx;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    // serial datapath
    always_ff @(posedge i_clk) begin
        r_opnd  <= n_opnd;
        r_carry <= n_carry;
        r_acc   <= n_acc;
        r_neg   <= n_neg;
        r_rem   <= n_rem;
        r_out   <= n_out;
    end

`include "pcm_channel_downmix_macros.svh"

    `PDM_ASSERT_IMP(a_rem_below_div, i_clk, i_rst_n, r_state == S_DIV, r_rem < w_count)
    `PDM_ASSERT_IMP(a_result_from_out, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_OUT)
    `PDM_ASSERT_NXT(a_mid_frame_idle, i_clk, i_rst_n, w_add_done && !r_last, r_state == S_IDLE)
    `PDM_ASSERT_NXT(a_frame_end_clear, i_clk, i_rst_n, w_add_done && r_last, w_frame_clear)

endmodule
